// ----- hw/rtl/irc90_pkg.sv -----
// Shared constants and controller/datapath interface types for the 90-degree rotator.
package irc90_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DIM_W       = 7;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic load_we;   // write the accepted pixel to the frame store
    logic fetch;     // read the next rotated pixel and advance the fetch counters
    logic out_load;  // move the read data into the output register
  } irc90_cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds a result that is not taken this cycle
  } irc90_stat_t;

endpackage

// ----- hw/rtl/irc90_ctrl.sv -----
// Controller state machine: input handshake and sequencing of store reads.
module irc90_ctrl import irc90_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_mode,
  output logic        in_ready,
  input  irc90_stat_t stat,
  output irc90_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load_we  = accept && (in_mode == MODE_LOAD);
    cmd.fetch    = accept && (in_mode == MODE_FETCH);
    cmd.out_load = (state_r == S_READ) && !stat.out_busy;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.fetch) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (cmd.out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/irc90_dp.sv -----
// Datapath: size registers, load and fetch counters, frame store and output register.
module irc90_dp import irc90_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  irc90_cmd_t            cmd,
  output irc90_stat_t           stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CH_W-1:0]       in_ch0,
  input  logic [CH_W-1:0]       in_ch1,
  input  logic [CH_W-1:0]       in_ch2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_ch0,
  output logic [CH_W-1:0]       out_ch1,
  output logic [CH_W-1:0]       out_ch2,
  output logic                  out_frame_end
);

  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [ADDR_W:0]   frame_size;

  logic [ADDR_W-1:0] load_idx_r;
  logic [ADDR_W-1:0] load_idx_nxt;
  logic [ADDR_W:0]   load_inc;

  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  rows_r;
  logic [ROW_W-1:0]  rows_nxt;
  logic [ROW_W:0]    rows_inc;
  logic [COL_W:0]    col_inc;
  logic              last;

  logic [ROW_W-1:0]  src_row;
  logic [COL_W-1:0]  src_col;
  logic [DIM_W-1:0]  row_tmp;
  logic [DIM_W-1:0]  col_tmp;
  logic [ADDR_W-1:0] rd_addr;

  logic [PIX_W-1:0]  mem [STORE_DEPTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic              last_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_end_r;

  // Out-of-range sizes saturate to 1..MAX.
  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign frame_size = (ADDR_W+1)'(w_eff) * (ADDR_W+1)'(h_eff);

  always_comb begin
    load_inc = {1'b0, load_idx_r} + (ADDR_W+1)'(1);
    if (load_inc >= frame_size) begin
      load_idx_nxt = '0;
    end else begin
      load_idx_nxt = load_inc[ADDR_W-1:0];
    end
  end

  // Source coordinate of the next rotated pixel: rows run bottom to top.
  always_comb begin
    row_tmp = '0;
    col_tmp = w_eff - DIM_W'(1);
    if (DIM_W'(rows_r) < h_eff) begin
      row_tmp = h_eff - DIM_W'(1) - DIM_W'(rows_r);
    end
    if (DIM_W'(col_r) < w_eff) begin
      col_tmp = DIM_W'(col_r);
    end
    src_row = row_tmp[ROW_W-1:0];
    src_col = col_tmp[COL_W-1:0];
    rd_addr = ADDR_W'(src_row) * ADDR_W'(w_eff) + ADDR_W'(src_col);
  end

  always_comb begin
    rows_inc = {1'b0, rows_r} + (ROW_W+1)'(1);
    col_inc  = {1'b0, col_r} + (COL_W+1)'(1);
    rows_nxt = rows_inc[ROW_W-1:0];
    col_nxt  = col_r;
    last     = 1'b0;
    if (DIM_W'(rows_inc) >= h_eff) begin
      rows_nxt = '0;
      if (DIM_W'(col_inc) >= w_eff) begin
        col_nxt = '0;
        last    = 1'b1;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_W'(MAX_WIDTH);
      height_r   <= DIM_W'(MAX_HEIGHT);
      load_idx_r <= '0;
      col_r      <= '0;
      rows_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_we) begin
        load_idx_r <= load_idx_nxt;
      end
      if (cmd.fetch) begin
        rows_r <= rows_nxt;
        col_r  <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[load_idx_r] <= {in_ch2, in_ch1, in_ch0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data_r <= mem[rd_addr];
      last_r    <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r <= rd_data_r;
      out_end_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_busy  = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_ch0        = out_pix_r[CH_W-1:0];
  assign out_ch1        = out_pix_r[2*CH_W-1:CH_W];
  assign out_ch2        = out_pix_r[PIX_W-1:2*CH_W];
  assign out_frame_end  = out_end_r;

endmodule

// ----- hw/rtl/image_rotate_clockwise_90_top.sv -----
// Top level of the 90-degree clockwise image rotator.
// Rotates a three-channel 8-bit image of up to 64 by 64 pixels through a
// frame store. Each input transaction carries in_mode: a load transaction
// writes its pixel to the store in raster order and gives no result; a fetch
// transaction gives one pixel of the rotated image on the output channel, in
// raster order of the rotated image, with out_frame_end set on its last pixel.
// The configuration channel writes image_width (index 0) and image_height
// (index 1); it is always ready and should be used only while the block is idle.
// Loads are taken one per cycle while in_ready is high. A fetch holds in_ready low
// in the read state until its read data moves into the output register, so the
// block takes no new item before the read state ends; out_valid rises when the output register is loaded.
// The output register lets the next transaction be taken while a result waits;
// when the receiver stalls, a second fetch waits in the read state and in_ready
// stays low until the output register frees.
// Reset clears the counters, the output valid and sets both sizes to 64; the
// store is not cleared, so a frame must be loaded before it is fetched.
module image_rotate_clockwise_90_top import irc90_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [CH_W-1:0]       in_ch0,
  input  logic [CH_W-1:0]       in_ch1,
  input  logic [CH_W-1:0]       in_ch2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_ch0,
  output logic [CH_W-1:0]       out_ch1,
  output logic [CH_W-1:0]       out_ch2,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  irc90_cmd_t  cmd;
  irc90_stat_t stat;

  assign cfg_ready = 1'b1;

  irc90_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  irc90_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch0        (in_ch0),
    .in_ch1        (in_ch1),
    .in_ch2        (in_ch2),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ch0       (out_ch0),
    .out_ch1       (out_ch1),
    .out_ch2       (out_ch2),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the 90-degree clockwise image rotator.
module tb_top;
  import irc90_pkg::*;

  localparam int ITEMS_TARGET = 1900;
  localparam int CALM_AFTER   = 1650;
  localparam int HOLD_CYCLES  = 300;
  localparam int FRAME_CAP    = 256;

  typedef struct packed {
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch0;
    logic            frame_end;
  } rot_pixel_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [DIM_W-1:0]     reg_val;
    logic                 mode;
    logic [PIX_W-1:0]     pix;
    logic                 typed;
    logic [PIX_W-1:0]     want_pix;
    logic                 want_end;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [CH_W-1:0]       in_ch0;
  logic [CH_W-1:0]       in_ch1;
  logic [CH_W-1:0]       in_ch2;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       out_ch0;
  logic [CH_W-1:0]       out_ch1;
  logic [CH_W-1:0]       out_ch2;
  logic                  out_frame_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the rotator state.
  logic [PIX_W-1:0] rot_store [STORE_DEPTH];
  bit               pix_loaded [STORE_DEPTH];
  int unsigned      load_pos  = 0;
  int unsigned      fetch_col = 0;
  int unsigned      rows_done = 0;
  logic [DIM_W-1:0] width_reg  = 7'd64;
  logic [DIM_W-1:0] height_reg = 7'd64;

  rot_pixel_t  pending_pixels [$];
  script_row_t script [$];

  int items_sent, loads_sent, fetches_sent, results_seen, regs_written, mismatches;
  int tx_odds, rx_odds;
  bit calm, hold_req, pressure_done;

  image_rotate_clockwise_90_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_ch0        (in_ch0),
    .in_ch1        (in_ch1),
    .in_ch2        (in_ch2),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ch0       (out_ch0),
    .out_ch1       (out_ch1),
    .out_ch2       (out_ch2),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Store address that the next fetch reads; counters past the frame pin to its edge.
  function automatic int unsigned next_fetch_addr();
    int unsigned w;
    int unsigned h;
    int unsigned row;
    int unsigned col;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    row = (rows_done < h) ? (h - 1 - rows_done) : 0;
    col = (fetch_col < w) ? fetch_col : (w - 1);
    return row * w + col;
  endfunction

  task automatic store_pixel(input logic [PIX_W-1:0] pix);
    int unsigned addr;
    int unsigned frame;
    frame = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
    addr = load_pos % STORE_DEPTH;
    rot_store[addr] = pix;
    pix_loaded[addr] = 1'b1;
    load_pos = (addr + 1 >= frame) ? 0 : addr + 1;
  endtask

  function automatic rot_pixel_t next_rotated();
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    rot_pixel_t r;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    addr = next_fetch_addr();
    {r.ch2, r.ch1, r.ch0} = rot_store[addr];
    r.frame_end = 1'b0;
    rows_done++;
    if (rows_done >= h) begin
      rows_done = 0;
      fetch_col++;
      if (fetch_col >= w) begin
        fetch_col = 0;
        r.frame_end = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 24;
    endcase
  endfunction

  task automatic send_pixel(input logic mode, input logic [PIX_W-1:0] pix, input bit typed,
                            input rot_pixel_t want);
    int gap;
    @(negedge clk);
    if (!calm && tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    {in_ch2, in_ch1, in_ch0} = pix;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (mode == MODE_LOAD) begin
      loads_sent++;
      store_pixel(pix);
    end else begin
      fetches_sent++;
      // Rows with a hand-written answer still advance the shadow counters.
      if (typed) begin
        void'(next_rotated());
        pending_pixels.push_back(want);
      end else begin
        pending_pixels.push_back(next_rotated());
      end
    end
  endtask

  // A fetch is only issued when the entry it reads has been loaded.
  task automatic random_item(input bit want_fetch);
    logic [PIX_W-1:0] pix;
    logic mode;
    pix = PIX_W'($urandom);
    mode = (want_fetch && pix_loaded[next_fetch_addr()]) ? MODE_FETCH : MODE_LOAD;
    send_pixel(mode, pix, 1'b0, '0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // A trailing load may still be in flight after the last result.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_IMAGE_WIDTH) width_reg = val;
    else if (sel == REG_IMAGE_HEIGHT) height_reg = val;
    regs_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DIM_W-1:0] val);
    script_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.reg_val = val;
    script.push_back(row);
  endtask

  task automatic add_load(input logic [PIX_W-1:0] pix);
    script_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.mode = MODE_LOAD;
    row.pix = pix;
    script.push_back(row);
  endtask

  task automatic add_fetch(input bit typed, input logic [PIX_W-1:0] want_pix, input bit want_end);
    script_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.mode = MODE_FETCH;
    row.pix = PIX_W'($urandom);
    row.typed = typed;
    row.want_pix = want_pix;
    row.want_end = want_end;
    script.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rot_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h %h %h end=%b", $time,
                 out_ch2, out_ch1, out_ch0, out_frame_end);
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_ch0", want.ch0, out_ch0);
        check_field("out_ch1", want.ch1, out_ch1);
        check_field("out_ch2", want.ch2, out_ch2);
        check_field("out_frame_end", {7'd0, want.frame_end}, {7'd0, out_frame_end});
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int pick;
    int unsigned frame;
    logic [DIM_W-1:0] wv;
    logic [DIM_W-1:0] hv;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD;
    in_ch0 = '0;
    in_ch1 = '0;
    in_ch2 = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    tx_odds = 4;
    rx_odds = 4;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 2x2 frame: load extremes, read back rotated, then one wrapped fetch.
    add_reg(REG_IMAGE_WIDTH, 7'd2);
    add_reg(REG_IMAGE_HEIGHT, 7'd2);
    add_load(24'h000000);
    add_load(24'hFFFFFF);
    add_load(24'h0F5AA5);
    add_load(24'hF08001);
    add_fetch(1, 24'h0F5AA5, 0);
    add_fetch(1, 24'h000000, 0);
    add_fetch(1, 24'hF08001, 0);
    add_fetch(1, 24'hFFFFFF, 1);
    add_fetch(1, 24'h0F5AA5, 0);
    // Zero sizes saturate to 1x1; the row counter is already past the frame.
    add_reg(REG_IMAGE_WIDTH, 7'd0);
    add_reg(REG_IMAGE_HEIGHT, 7'd0);
    add_fetch(1, 24'h000000, 1);
    // Shrink while the load counter sits past the new frame.
    add_reg(REG_IMAGE_WIDTH, 7'd2);
    add_reg(REG_IMAGE_HEIGHT, 7'd2);
    add_load(24'h123456);
    add_load(24'h807F01);
    add_load(24'h55AA33);
    add_reg(REG_IMAGE_WIDTH, 7'd1);
    add_reg(REG_IMAGE_HEIGHT, 7'd2);
    add_load(24'hC3E1FE);
    add_fetch(1, 24'h807F01, 0);
    add_fetch(1, 24'h123456, 1);
    // Oversized width saturates to the maximum; the last fetch reads the past-frame write.
    add_reg(REG_IMAGE_WIDTH, 7'd127);
    add_reg(REG_IMAGE_HEIGHT, 7'd1);
    add_fetch(1, 24'h123456, 0);
    add_fetch(1, 24'h807F01, 0);
    add_fetch(0, '0, 0);
    add_fetch(0, '0, 0);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(script[i].reg_sel, script[i].reg_val);
      end else begin
        send_pixel(script[i].mode, script[i].pix, script[i].typed,
                   {script[i].want_pix, script[i].want_end});
      end
    end

    phase = 0;
    while (items_sent < ITEMS_TARGET || results_seen < 48) begin
      wait_idle();
      calm = (items_sent >= CALM_AFTER);
      tx_odds = calm ? 0 : pick_odds();
      rx_odds = calm ? 0 : pick_odds();
      pick = $urandom_range(0, 19);
      if (phase == 2) begin
        wv = 7'd2;
        hv = 7'd64;
      end else if (phase == 5) begin
        wv = 7'd64;
        hv = 7'd1;
      end else if (pick == 0) begin
        wv = 7'd64;
        hv = DIM_W'($urandom_range(1, 3));
      end else if (pick == 1) begin
        wv = DIM_W'($urandom_range(1, 3));
        hv = 7'd64;
      end else if (pick < 6) begin
        wv = DIM_W'($urandom_range(9, 16));
        hv = DIM_W'($urandom_range(9, 16));
      end else begin
        wv = DIM_W'($urandom_range(1, 8));
        hv = DIM_W'($urandom_range(1, 8));
      end
      // Out-of-range encodings that saturate to the same effective size.
      if (wv == 64 && $urandom_range(0, 1)) wv = DIM_W'($urandom_range(65, 127));
      if (hv == 64 && $urandom_range(0, 1)) hv = DIM_W'($urandom_range(65, 127));
      if (wv == 1 && $urandom_range(0, 1)) wv = 7'd0;
      if (hv == 1 && $urandom_range(0, 1)) hv = 7'd0;
      // Sometimes a register keeps its old value, so counters run against a mixed size.
      if (phase < 3 || $urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, wv);
      if (phase < 3 || $urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, hv);
      frame = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
      // A mixed size can reach a full 64x64 frame; that one only gets a short random run.
      if (frame <= FRAME_CAP && $urandom_range(0, 9) < 7) begin
        repeat (frame) random_item(1'b0);
        if (!pressure_done && !calm && frame >= 4) begin
          hold_req = 1'b1;
          pressure_done = 1'b1;
        end
        repeat (frame) random_item(1'b1);
      end else begin
        repeat ($urandom_range(4, 40)) random_item(1'($urandom_range(0, 1)));
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      mismatches++;
      $display("%0t: %0d rotated pixels expected but never delivered", $time,
               pending_pixels.size());
    end
    $display("Ran %0d pixel transactions (%0d loads, %0d fetches) across %0d register writes.",
             items_sent, loads_sent, fetches_sent, regs_written);
    $display("Compared %0d rotated pixels; %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
